### hdl/tkd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tkd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KeyW   = 4;
  localparam int unsigned DataW  = 32;
  localparam int unsigned LenW   = 3;
  localparam int unsigned LeftW  = 2;
  localparam int unsigned MaxLen = 4;

  typedef enum logic [KeyW-1:0] {
    KeyChar      = 4'd0,
    KeyDefault   = 4'd1,
    KeyDelete    = 4'd2,
    KeyHome      = 4'd3,
    KeyEnd       = 4'd4,
    KeyUp        = 4'd5,
    KeyDown      = 4'd6,
    KeyRight     = 4'd7,
    KeyLeft      = 4'd8,
    KeyBackspace = 4'd9,
    KeyEof       = 4'd10,
    KeyReturn    = 4'd11,
    KeyTab       = 4'd12
  } key_e;

  typedef enum logic [2:0] {
    ModeIdle = 3'd0,
    ModeEsc1 = 3'd1,
    ModeEsc2 = 3'd2,
    ModeEsc3 = 3'd3,
    ModeUtf8 = 3'd4
  } mode_e;

  localparam logic [ByteW-1:0] ChEsc     = 8'h1b;
  localparam logic [ByteW-1:0] ChDel     = 8'h7f;
  localparam logic [ByteW-1:0] ChEot     = 8'h04;
  localparam logic [ByteW-1:0] ChLf      = 8'h0a;
  localparam logic [ByteW-1:0] ChTab     = 8'h09;
  localparam logic [ByteW-1:0] ChBracket = 8'h5b;
  localparam logic [ByteW-1:0] ChTilde   = 8'h7e;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChNine    = 8'h39;
  localparam logic [ByteW-1:0] ChOne     = 8'h31;
  localparam logic [ByteW-1:0] ChThree   = 8'h33;
  localparam logic [ByteW-1:0] ChFour    = 8'h34;
  localparam logic [ByteW-1:0] ChSeven   = 8'h37;
  localparam logic [ByteW-1:0] ChEight   = 8'h38;
  localparam logic [ByteW-1:0] ChA       = 8'h41;
  localparam logic [ByteW-1:0] ChB       = 8'h42;
  localparam logic [ByteW-1:0] ChC       = 8'h43;
  localparam logic [ByteW-1:0] ChD       = 8'h44;
  localparam logic [ByteW-1:0] ChF       = 8'h46;
  localparam logic [ByteW-1:0] ChH       = 8'h48;
  localparam logic [ByteW-1:0] Lead2Lo   = 8'hc0;
  localparam logic [ByteW-1:0] Lead2Hi   = 8'hdf;
  localparam logic [ByteW-1:0] Lead3Lo   = 8'he0;
  localparam logic [ByteW-1:0] Lead3Hi   = 8'hef;
  localparam logic [ByteW-1:0] Lead4Lo   = 8'hf0;
  localparam logic [ByteW-1:0] Lead4Hi   = 8'hf7;

endpackage
`default_nettype wire

### hdl/terminal_key_sequence_decoder_top.sv
// A word appears on the output when its last byte has passed the input register
// and the result register loads; a stalled word can hold that byte in between.
// Throughput: one byte per cycle; while a finished word is stalled, one more byte
// waits in the input register and input ready drops until the word leaves.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to idle with no partial escape sequence or UTF-8 character.
`timescale 1ns / 1ps
`default_nettype none
module terminal_key_sequence_decoder_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [tkd_pkg::ByteW-1:0] rx_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [tkd_pkg::KeyW-1:0]       key_code_o,
  output logic [tkd_pkg::DataW-1:0]      char_data_o,
  output logic [tkd_pkg::LenW-1:0]       char_len_o
);
  import tkd_pkg::*;

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             consume;

  mode_e            mode_q, mode_d;
  logic [ByteW-1:0] first_q, first_d;
  logic [ByteW-1:0] second_q, second_d;
  logic [DataW-1:0] accum_q, accum_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [LenW-1:0]  total_q, total_d;

  logic             emit;
  key_e             res_key;
  logic [DataW-1:0] res_data;
  logic [LenW-1:0]  res_len;

  logic             out_valid_q;
  key_e             key_q;
  logic [DataW-1:0] data_q;
  logic [LenW-1:0]  len_q;

  logic [LenW-1:0]  total_inc;
  logic [LeftW-1:0] left_dec;
  logic [DataW-1:0] accum_upd;
  logic             utf8_done;
  logic             is_digit;
  logic [LeftW-1:0] extra;

  function automatic key_e decode_seq(logic [ByteW-1:0] b1, logic [ByteW-1:0] b2,
                                      logic has_third);
    key_e k;
    k = KeyDefault;
    if (b1 == ChA) k = KeyUp;
    else if (b1 == ChB) k = KeyDown;
    else if (b1 == ChC) k = KeyRight;
    else if (b1 == ChD) k = KeyLeft;
    else if (b1 == ChH) k = KeyHome;
    else if (b1 == ChF) k = KeyEnd;
    if (has_third && b2 == ChTilde) begin
      if (b1 == ChThree) k = KeyDelete;
      else if (b1 == ChOne || b1 == ChSeven) k = KeyHome;
      else if (b1 == ChFour || b1 == ChEight) k = KeyEnd;
    end
    return k;
  endfunction

  // Input register.
  assign consume    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || consume;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Shared arithmetic for the UTF-8 gather, and the digit test for escape sequences.
  assign total_inc = total_q + LenW'(1);
  assign left_dec  = left_q - LeftW'(1);
  assign utf8_done = (left_dec == '0) || (total_inc >= LenW'(MaxLen));
  assign accum_upd = (total_q < LenW'(MaxLen))
                   ? (accum_q | (DataW'(in_byte_q) << {total_q[1:0], 3'b000}))
                   : accum_q;
  assign is_digit  = (in_byte_q >= ChZero) && (in_byte_q <= ChNine);

  always_comb begin
    extra = '0;
    if (in_byte_q >= Lead2Lo && in_byte_q <= Lead2Hi) extra = LeftW'(1);
    else if (in_byte_q >= Lead3Lo && in_byte_q <= Lead3Hi) extra = LeftW'(2);
    else if (in_byte_q >= Lead4Lo && in_byte_q <= Lead4Hi) extra = LeftW'(3);
  end

  // Next parse state.
  always_comb begin
    mode_d   = mode_q;
    first_d  = first_q;
    second_d = second_q;
    accum_d  = accum_q;
    left_d   = left_q;
    total_d  = total_q;
    unique case (mode_q)
      ModeEsc1: begin
        first_d = in_byte_q;
        mode_d  = ModeEsc2;
      end
      ModeEsc2: begin
        second_d = in_byte_q;
        if (first_q == ChBracket && is_digit) mode_d = ModeEsc3;
        else mode_d = ModeIdle;
      end
      ModeEsc3: begin
        mode_d = ModeIdle;
      end
      ModeUtf8: begin
        accum_d = accum_upd;
        total_d = total_inc;
        left_d  = left_dec;
        if (utf8_done) begin
          mode_d = ModeIdle;
          left_d = '0;
        end
      end
      default: begin
        mode_d = ModeIdle;
        if (in_byte_q == ChEsc) begin
          mode_d = ModeEsc1;
        end else if (in_byte_q != ChDel && in_byte_q != ChEot && in_byte_q != ChLf &&
                     in_byte_q != ChTab && extra != '0) begin
          accum_d = DataW'(in_byte_q);
          total_d = LenW'(1);
          left_d  = extra;
          mode_d  = ModeUtf8;
        end
      end
    endcase
  end

  // Result of the current byte.
  always_comb begin
    emit     = 1'b0;
    res_key  = KeyDefault;
    res_data = '0;
    res_len  = '0;
    unique case (mode_q)
      ModeEsc1: begin
        emit = 1'b0;
      end
      ModeEsc2: begin
        if (first_q != ChBracket) begin
          emit    = 1'b1;
          res_key = KeyDefault;
        end else if (!is_digit) begin
          emit    = 1'b1;
          res_key = decode_seq(in_byte_q, '0, 1'b0);
        end
      end
      ModeEsc3: begin
        emit    = 1'b1;
        res_key = decode_seq(second_q, in_byte_q, 1'b1);
      end
      ModeUtf8: begin
        if (utf8_done) begin
          emit     = 1'b1;
          res_key  = KeyChar;
          res_data = accum_upd;
          res_len  = total_inc;
        end
      end
      default: begin
        priority if (in_byte_q == ChEsc) begin
          emit = 1'b0;
        end else if (in_byte_q == ChDel) begin
          emit    = 1'b1;
          res_key = KeyBackspace;
        end else if (in_byte_q == ChEot) begin
          emit    = 1'b1;
          res_key = KeyEof;
        end else if (in_byte_q == ChLf) begin
          emit    = 1'b1;
          res_key = KeyReturn;
        end else if (in_byte_q == ChTab) begin
          emit    = 1'b1;
          res_key = KeyTab;
        end else if (extra != '0) begin
          emit = 1'b0;
        end else begin
          emit     = 1'b1;
          res_key  = KeyChar;
          res_data = DataW'(in_byte_q);
          res_len  = LenW'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      first_q  <= '0;
      second_q <= '0;
      accum_q  <= '0;
      left_q   <= '0;
      total_q  <= '0;
    end else if (consume) begin
      mode_q   <= mode_d;
      first_q  <= first_d;
      second_q <= second_d;
      accum_q  <= accum_d;
      left_q   <= left_d;
      total_q  <= total_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && emit) begin
      key_q  <= res_key;
      data_q <= res_data;
      len_q  <= res_len;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_code_o  = key_q;
  assign char_data_o = data_q;
  assign char_len_o  = len_q;

endmodule
`default_nettype wire

### hdl/tkd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tkd_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic [tkd_pkg::ByteW-1:0] rx_byte_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic [tkd_pkg::KeyW-1:0]  key_code_o,
  input wire logic [tkd_pkg::DataW-1:0] char_data_o,
  input wire logic [tkd_pkg::LenW-1:0]  char_len_o
);
  import tkd_pkg::*;

  // A stalled word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_code_o) &&
    $stable(char_data_o) && $stable(char_len_o))
    else $error("output word changed while stalled");

  // Non-character keys carry no character bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_code_o != KeyChar |-> char_len_o == '0 && char_data_o == '0)
    else $error("non-character key with character data");

  // A character word holds one to four bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_code_o == KeyChar |-> char_len_o != '0 &&
    char_len_o <= LenW'(MaxLen))
    else $error("character word with bad length");

  // When the result side can move, the input side is never blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("input blocked with the output free");

  // A waiting input word holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(rx_byte_i))
    else $error("input word changed while waiting");

endmodule

bind terminal_key_sequence_decoder_top tkd_checker u_tkd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .rx_byte_i   (rx_byte_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .key_code_o  (key_code_o),
  .char_data_o (char_data_o),
  .char_len_o  (char_len_o)
);
`default_nettype wire
